// ===== rtl/dfe_pkg.sv =====
// Shared types, constants and register indexes for the DShot frame encoder.
package dfe_pkg;

  // Frame layout
  localparam int FRAME_BITS   = 16;
  localparam int MOTOR_FIELDS = 4;
  localparam int PULSE_W      = 16;
  localparam int DUTY_W       = 9;
  localparam int SLOT_W       = 5;
  localparam int THR_W        = 11;
  localparam int PROD_W       = 21;
  localparam int WR_INDEX_W   = 1;

  // Defaults for top-level parameters
  localparam int GAP_SLOTS_DEFAULT    = 2;
  localparam int MOTOR_COUNT_DEFAULT  = 4;
  localparam int PERIOD_TICKS_DEFAULT = 480;

  // Throttle mapping: 48 + (w - 1000) * 1999 / 1000, clamped to 2047
  localparam logic [PULSE_W-1:0] PULSE_MIN  = 16'd1000;
  localparam logic [PULSE_W-1:0] PULSE_MAX  = 16'd2000;
  localparam logic [PROD_W-1:0]  THR_SCALE  = 21'd1999;
  localparam logic [THR_W:0]     THR_OFFSET = 12'd48;
  localparam logic [THR_W:0]     THR_MAX    = 12'd2047;

  // Divide by 1000 as multiply by ceil(2^30 / 1000), exact for products below 2^21
  localparam logic [PROD_W-1:0]  RECIP_1000  = 21'd1073742;
  localparam int                 RECIP_SHIFT = 30;

  // Register reset values
  localparam logic [DUTY_W-1:0] ZERO_DUTY_RESET = 9'd180;
  localparam logic [DUTY_W-1:0] ONE_DUTY_RESET  = 9'd360;

  // Register indexes
  localparam logic [WR_INDEX_W-1:0] REG_ZERO_BIT_DUTY = 1'b0;
  localparam logic [WR_INDEX_W-1:0] REG_ONE_BIT_DUTY  = 1'b1;

  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef struct packed {
    logic [PULSE_W-1:0] pulse_motor_one;
    logic [PULSE_W-1:0] pulse_motor_two;
    logic [PULSE_W-1:0] pulse_motor_three;
    logic [PULSE_W-1:0] pulse_motor_four;
  } pulse_item_t;

  typedef struct packed {
    logic [DUTY_W-1:0] duty_motor_one;
    logic [DUTY_W-1:0] duty_motor_two;
    logic [DUTY_W-1:0] duty_motor_three;
    logic [DUTY_W-1:0] duty_motor_four;
    logic [SLOT_W-1:0] slot_number;
    logic              last_slot;
  } duty_result_t;

endpackage

// ===== rtl/dfe_lane.sv =====
// One motor lane: pulse width to throttle to 16-bit DShot frame, three stages.
module dfe_lane (
  input  logic                            clk,
  input  logic [dfe_pkg::PULSE_W-1:0]     pulse,
  output dfe_pkg::frame_t                 frame
);

  logic [dfe_pkg::PULSE_W-1:0]         clamped;
  logic [dfe_pkg::PULSE_W-1:0]         offset;
  logic [dfe_pkg::PROD_W-1:0]          prod;
  logic [2*dfe_pkg::PROD_W-1:0]        quot_full;
  logic [dfe_pkg::THR_W-1:0]           quot;
  logic [dfe_pkg::THR_W:0]             thr_sum;
  logic [dfe_pkg::THR_W-1:0]           throttle;
  logic [dfe_pkg::THR_W:0]             value;
  logic [3:0]                          csum;

  // Stage 1: clamp and scale by 1999
  always_comb begin
    if (pulse < dfe_pkg::PULSE_MIN) begin
      clamped = dfe_pkg::PULSE_MIN;
    end else if (pulse > dfe_pkg::PULSE_MAX) begin
      clamped = dfe_pkg::PULSE_MAX;
    end else begin
      clamped = pulse;
    end
    offset = clamped - dfe_pkg::PULSE_MIN;
  end

  always_ff @(posedge clk) begin
    prod <= dfe_pkg::PROD_W'(offset) * dfe_pkg::THR_SCALE;
  end

  // Stage 2: truncating divide by 1000 through the reciprocal
  assign quot_full = (2*dfe_pkg::PROD_W)'(prod) * (2*dfe_pkg::PROD_W)'(dfe_pkg::RECIP_1000);

  always_ff @(posedge clk) begin
    quot <= quot_full[dfe_pkg::RECIP_SHIFT +: dfe_pkg::THR_W];
  end

  // Stage 3: offset, clamp, telemetry bit cleared, checksum appended
  always_comb begin
    thr_sum = (dfe_pkg::THR_W+1)'(quot) + dfe_pkg::THR_OFFSET;
    if (thr_sum > dfe_pkg::THR_MAX) begin
      throttle = dfe_pkg::THR_MAX[dfe_pkg::THR_W-1:0];
    end else begin
      throttle = thr_sum[dfe_pkg::THR_W-1:0];
    end
    value = {throttle, 1'b0};
    csum  = value[3:0] ^ value[7:4] ^ value[11:8];
  end

  always_ff @(posedge clk) begin
    frame <= {value, csum};
  end

endmodule

// ===== rtl/dfe_slot_emitter.sv =====
// Merges the lane frames into one slot stream: hold buffer, bit shifters, slot counter.
module dfe_slot_emitter #(
  parameter int GAP_SLOTS    = dfe_pkg::GAP_SLOTS_DEFAULT,
  parameter int MOTOR_COUNT  = dfe_pkg::MOTOR_COUNT_DEFAULT,
  parameter int PERIOD_TICKS = dfe_pkg::PERIOD_TICKS_DEFAULT
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        frame_valid,
  input  dfe_pkg::frame_t             frames [dfe_pkg::MOTOR_FIELDS],
  input  logic [dfe_pkg::DUTY_W-1:0]  zero_bit_duty,
  input  logic [dfe_pkg::DUTY_W-1:0]  one_bit_duty,
  output logic                        hold_valid,
  output logic                        strobe,
  output dfe_pkg::duty_result_t       result
);

  localparam int TOTAL_SLOTS = dfe_pkg::FRAME_BITS + GAP_SLOTS;
  localparam logic [dfe_pkg::SLOT_W-1:0] LAST_SLOT = dfe_pkg::SLOT_W'(TOTAL_SLOTS - 1);
  localparam logic [dfe_pkg::SLOT_W-1:0] FRAME_END = dfe_pkg::SLOT_W'(dfe_pkg::FRAME_BITS);
  localparam logic [dfe_pkg::SLOT_W-1:0] SLOT_ONE  = dfe_pkg::SLOT_W'(1);
  localparam logic [dfe_pkg::DUTY_W-1:0] DUTY_SAT  = dfe_pkg::DUTY_W'(PERIOD_TICKS - 1);

  dfe_pkg::frame_t                hold   [dfe_pkg::MOTOR_FIELDS];
  dfe_pkg::frame_t                shifter[dfe_pkg::MOTOR_FIELDS];
  logic [dfe_pkg::SLOT_W-1:0]     slot;
  logic                           emit_active;
  logic                           last;
  logic                           load;
  logic [dfe_pkg::DUTY_W-1:0]     zero_sat;
  logic [dfe_pkg::DUTY_W-1:0]     one_sat;
  logic [dfe_pkg::DUTY_W-1:0]     duty   [dfe_pkg::MOTOR_FIELDS];

  assign last = emit_active && (slot == LAST_SLOT);
  assign load = hold_valid && (!emit_active || last);

  // Hold buffer for the next frame set
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (frame_valid) begin
      hold_valid <= 1'b1;
    end else if (load) begin
      hold_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (frame_valid) begin
      hold <= frames;
    end
  end

  // Slot counter and per-motor bit shifters
  always_ff @(posedge clk) begin
    if (rst) begin
      emit_active <= 1'b0;
      slot        <= '0;
    end else if (load) begin
      emit_active <= 1'b1;
      slot        <= '0;
    end else if (emit_active) begin
      if (last) begin
        emit_active <= 1'b0;
      end
      slot <= slot + SLOT_ONE;
    end
  end

  always_ff @(posedge clk) begin
    for (int m = 0; m < dfe_pkg::MOTOR_FIELDS; m++) begin
      if (load) begin
        shifter[m] <= hold[m];
      end else if (emit_active) begin
        shifter[m] <= {shifter[m][dfe_pkg::FRAME_BITS-2:0], 1'b0};
      end
    end
  end

  // Duty saturation against the timer period
  always_comb begin
    zero_sat = (32'(zero_bit_duty) >= 32'(PERIOD_TICKS)) ? DUTY_SAT : zero_bit_duty;
    one_sat  = (32'(one_bit_duty) >= 32'(PERIOD_TICKS)) ? DUTY_SAT : one_bit_duty;
  end

  // Per-motor duty select; unused motors and gap slots carry zero
  always_comb begin
    for (int m = 0; m < dfe_pkg::MOTOR_FIELDS; m++) begin
      if ((m < MOTOR_COUNT) && (slot < FRAME_END)) begin
        duty[m] = shifter[m][dfe_pkg::FRAME_BITS-1] ? one_sat : zero_sat;
      end else begin
        duty[m] = '0;
      end
    end
  end

  assign strobe = emit_active;

  always_comb begin
    result.duty_motor_one   = duty[0];
    result.duty_motor_two   = duty[1];
    result.duty_motor_three = duty[2];
    result.duty_motor_four  = duty[3];
    result.slot_number      = slot;
    result.last_slot        = last;
  end

  // Slot number stays inside the frame while a transaction is out
  a_slot_range: assert property (@(posedge clk) disable iff (rst)
    emit_active |-> (slot <= LAST_SLOT))
    else $error("slot counter ran past the last slot");

  // A new frame set never lands on a full hold buffer that is not draining
  a_hold_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    frame_valid |-> (!hold_valid || load))
    else $error("hold buffer overwritten");

  // Slots advance by one each cycle within a frame
  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    (emit_active && !last) |=> (emit_active && (slot == $past(slot) + SLOT_ONE)))
    else $error("slot sequence broken");

  // After the last slot the stream stops unless the next frame set starts at slot zero
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    (last && !hold_valid) |=> !emit_active)
    else $error("emission continued past the frame end");

endmodule

// ===== rtl/dshot_frame_encoder_unit.sv =====
// Top level of the DShot frame encoder: config registers, motor lanes, slot emitter.
//
// A transaction on start/busy carries four pulse widths; each motor lane turns its
// width into a 16-bit DShot frame in three pipeline stages, and the frames wait in a
// hold buffer until the slot emitter is free. The emitter then puts out
// 16 + GAP_SLOTS result slots, one per cycle, each marked by strobe for exactly one
// cycle; the receiver cannot stall them. A frame set passes the lane stages and the
// hold buffer register before its first slot appears. busy stays high while a frame
// set is in the lanes or in the hold buffer, so a new transaction is taken while the
// last set is still emitted, paced by the single shared result port. Duty registers
// are written through wr_en/wr_index/wr_data and take effect on the next slot.
module dshot_frame_encoder_unit #(
  parameter int GAP_SLOTS    = dfe_pkg::GAP_SLOTS_DEFAULT,
  parameter int MOTOR_COUNT  = dfe_pkg::MOTOR_COUNT_DEFAULT,
  parameter int PERIOD_TICKS = dfe_pkg::PERIOD_TICKS_DEFAULT
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  dfe_pkg::pulse_item_t            pulses,
  output logic                            strobe,
  output dfe_pkg::duty_result_t           result,
  input  logic                            wr_en,
  input  logic [dfe_pkg::WR_INDEX_W-1:0]  wr_index,
  input  logic [dfe_pkg::DUTY_W-1:0]      wr_data
);

  localparam int LANES = (MOTOR_COUNT < dfe_pkg::MOTOR_FIELDS) ? MOTOR_COUNT
                                                               : dfe_pkg::MOTOR_FIELDS;

  logic [dfe_pkg::DUTY_W-1:0]   zero_bit_duty;
  logic [dfe_pkg::DUTY_W-1:0]   one_bit_duty;
  logic [dfe_pkg::PULSE_W-1:0]  pulse_arr [dfe_pkg::MOTOR_FIELDS];
  dfe_pkg::frame_t              frames    [dfe_pkg::MOTOR_FIELDS];
  logic [2:0]                   stage_valid;
  logic                         hold_valid;
  logic                         accept;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      zero_bit_duty <= dfe_pkg::ZERO_DUTY_RESET;
      one_bit_duty  <= dfe_pkg::ONE_DUTY_RESET;
    end else if (wr_en) begin
      case (wr_index)
        dfe_pkg::REG_ZERO_BIT_DUTY: zero_bit_duty <= wr_data;
        dfe_pkg::REG_ONE_BIT_DUTY:  one_bit_duty  <= wr_data;
        default: ;
      endcase
    end
  end

  // Input transaction and lane pipeline occupancy
  assign busy   = (|stage_valid) || hold_valid;
  assign accept = start && !busy;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= '0;
    end else begin
      stage_valid <= {stage_valid[1:0], accept};
    end
  end

  assign pulse_arr[0] = pulses.pulse_motor_one;
  assign pulse_arr[1] = pulses.pulse_motor_two;
  assign pulse_arr[2] = pulses.pulse_motor_three;
  assign pulse_arr[3] = pulses.pulse_motor_four;

  // One lane per active motor; unused motors carry an empty frame
  for (genvar g = 0; g < dfe_pkg::MOTOR_FIELDS; g++) begin : g_lane
    if (g < LANES) begin : g_on
      dfe_lane u_lane (
        .clk   (clk),
        .pulse (pulse_arr[g]),
        .frame (frames[g])
      );
    end else begin : g_off
      assign frames[g] = '0;
    end
  end

  dfe_slot_emitter #(
    .GAP_SLOTS    (GAP_SLOTS),
    .MOTOR_COUNT  (MOTOR_COUNT),
    .PERIOD_TICKS (PERIOD_TICKS)
  ) u_emitter (
    .clk           (clk),
    .rst           (rst),
    .frame_valid   (stage_valid[2]),
    .frames        (frames),
    .zero_bit_duty (zero_bit_duty),
    .one_bit_duty  (one_bit_duty),
    .hold_valid    (hold_valid),
    .strobe        (strobe),
    .result        (result)
  );

endmodule
